>>> hdl/pfp_pkg.sv
// Shared widths, types and register codes for the plane-from-three-points pipeline.
package pfp_pkg;

  localparam int CW   = 24;          // coordinate width
  localparam int FB   = 12;          // coordinate fraction bits
  localparam int DW   = CW + 1;      // edge vector component
  localparam int PW   = 2 * DW;      // signed product of a u and a v edge component
  localparam int MW   = PW - 1;      // normal component magnitude
  localparam int LOW  = (MW + 1) / 2;
  localparam int HIW  = MW - LOW;
  localparam int SQW  = 2 * MW;      // squared component
  localparam int SW   = SQW + 2;     // sum of squares
  localparam int RW   = SW / 2;      // root width
  localparam int RMW  = RW + 2;      // root remainder
  localparam int UFB  = 30;          // unit normal fraction bits
  localparam int QW   = UFB + 1;     // quotient magnitude
  localparam int OW   = 32;          // unit normal field
  localparam int PRW  = OW + CW;     // unit times coordinate
  localparam int AW   = PRW + 2;     // offset accumulator
  localparam int DOW  = CW + 1;      // offset field
  localparam int MNW  = 16;          // min_norm register
  localparam int AXW  = 3;           // config address
  localparam int IDW  = 9 * CW;
  localparam int ODW  = ((3 * OW + DOW + 7) / 8) * 8;

  localparam logic [0:0] REG_MIN_NORM = 1'b0;
  localparam logic [MNW-1:0] MIN_NORM_RESET = MNW'(17);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] unit_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
  } tri_t;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    point_t             p0;
  } side_t;

  typedef struct packed {
    logic   ok;
    unit_t  a;
    unit_t  b;
    unit_t  c;
    point_t p0;
  } plane_t;

endpackage

>>> hdl/pfp_cross.sv
// Edge vectors, cross product, component squares and their sum.
module pfp_cross (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  pfp_pkg::tri_t           in_tri,
  output logic                    out_valid,
  output logic [pfp_pkg::SW-1:0]  out_sum,
  output pfp_pkg::side_t          out_side
);

  logic [5:0] vld;

  pfp_pkg::point_t p0_1, p0_2;
  logic signed [pfp_pkg::DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [pfp_pkg::PW-1:0] pr [6];
  pfp_pkg::side_t sd3, sd4, sd5;
  logic [pfp_pkg::HIW*2-1:0]         hh [3];
  logic [pfp_pkg::HIW+pfp_pkg::LOW-1:0] hl [3];
  logic [pfp_pkg::LOW*2-1:0]         ll [3];
  logic [pfp_pkg::SQW-1:0]           sq [3];
  logic signed [pfp_pkg::PW:0]       nc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc[i] = (pfp_pkg::PW+1)'(pr[2*i]) - (pfp_pkg::PW+1)'(pr[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_1 <= in_tri.p0;
      ux <= pfp_pkg::DW'(in_tri.p1.x) - pfp_pkg::DW'(in_tri.p0.x);
      uy <= pfp_pkg::DW'(in_tri.p1.y) - pfp_pkg::DW'(in_tri.p0.y);
      uz <= pfp_pkg::DW'(in_tri.p1.z) - pfp_pkg::DW'(in_tri.p0.z);
      vx <= pfp_pkg::DW'(in_tri.p2.x) - pfp_pkg::DW'(in_tri.p0.x);
      vy <= pfp_pkg::DW'(in_tri.p2.y) - pfp_pkg::DW'(in_tri.p0.y);
      vz <= pfp_pkg::DW'(in_tri.p2.z) - pfp_pkg::DW'(in_tri.p0.z);

      p0_2  <= p0_1;
      pr[0] <= uy * vz;
      pr[1] <= uz * vy;
      pr[2] <= uz * vx;
      pr[3] <= ux * vz;
      pr[4] <= ux * vy;
      pr[5] <= uy * vx;

      sd3.p0 <= p0_2;
      for (int i = 0; i < 3; i++) begin
        sd3.neg[i] <= nc[i][pfp_pkg::PW];
        sd3.mag[i] <= nc[i][pfp_pkg::PW] ? pfp_pkg::MW'(-nc[i]) : pfp_pkg::MW'(nc[i]);
      end

      sd4 <= sd3;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= sd3.mag[i][pfp_pkg::MW-1:pfp_pkg::LOW] * sd3.mag[i][pfp_pkg::MW-1:pfp_pkg::LOW];
        hl[i] <= sd3.mag[i][pfp_pkg::MW-1:pfp_pkg::LOW] * sd3.mag[i][pfp_pkg::LOW-1:0];
        ll[i] <= sd3.mag[i][pfp_pkg::LOW-1:0] * sd3.mag[i][pfp_pkg::LOW-1:0];
      end

      sd5 <= sd4;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (pfp_pkg::SQW'(hh[i]) << (2 * pfp_pkg::LOW))
               + (pfp_pkg::SQW'(hl[i]) << (pfp_pkg::LOW + 1))
               + pfp_pkg::SQW'(ll[i]);
      end

      out_side <= sd5;
      out_sum  <= pfp_pkg::SW'(sq[0]) + pfp_pkg::SW'(sq[1]) + pfp_pkg::SW'(sq[2]);
    end
  end

  assign out_valid = vld[5];

endmodule

>>> hdl/pfp_sqrt.sv
// Floor square root, one root bit per pipeline stage.
module pfp_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [pfp_pkg::SW-1:0]  in_rad,
  input  pfp_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [pfp_pkg::RW-1:0]  out_root,
  output pfp_pkg::side_t          out_side
);

  logic                    vld  [pfp_pkg::RW+1];
  logic [pfp_pkg::RMW-1:0] rem  [pfp_pkg::RW+1];
  logic [pfp_pkg::RW-1:0]  root [pfp_pkg::RW+1];
  logic [pfp_pkg::SW-1:0]  rad  [pfp_pkg::RW+1];
  pfp_pkg::side_t          sd   [pfp_pkg::RW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = in_rad;
  assign sd[0]   = in_side;

  for (genvar i = 0; i < pfp_pkg::RW; i++) begin : g_stage
    logic [pfp_pkg::RMW-1:0] cand, trial;
    logic take;

    assign cand  = {rem[i][pfp_pkg::RMW-3:0], rad[i][2*(pfp_pkg::RW-1-i) +: 2]};
    assign trial = {root[i], 2'b01};
    assign take  = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? cand - trial : cand;
        root[i+1] <= {root[i][pfp_pkg::RW-2:0], take};
        rad[i+1]  <= rad[i];
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_valid = vld[pfp_pkg::RW];
  assign out_root  = root[pfp_pkg::RW];
  assign out_side  = sd[pfp_pkg::RW];

endmodule

>>> hdl/pfp_div.sv
// Normal over length: three restoring dividers, one quotient bit per stage, then rounding.
module pfp_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [pfp_pkg::MNW-1:0] min_norm,
  input  logic                    in_valid,
  input  logic [pfp_pkg::RW-1:0]  in_norm,
  input  pfp_pkg::side_t          in_side,
  output logic                    out_valid,
  output pfp_pkg::plane_t         out_plane
);

  logic                    vld  [pfp_pkg::QW+1];
  logic                    ok   [pfp_pkg::QW+1];
  logic [pfp_pkg::RW-1:0]  norm [pfp_pkg::QW+1];
  logic [pfp_pkg::RW-1:0]  rr   [pfp_pkg::QW+1][3];
  logic [pfp_pkg::QW-1:0]  qq   [pfp_pkg::QW+1][3];
  pfp_pkg::side_t          sd   [pfp_pkg::QW+1];
  logic                    vout;
  logic [pfp_pkg::QW-1:0]  qr   [3];

  assign vld[0]  = in_valid;
  assign ok[0]   = (in_norm != '0) && (in_norm >= pfp_pkg::RW'(min_norm));
  assign norm[0] = in_norm;
  assign sd[0]   = in_side;
  for (genvar j = 0; j < 3; j++) begin : g_init
    assign rr[0][j] = '0;
    assign qq[0][j] = '0;
  end

  for (genvar k = 0; k < pfp_pkg::QW; k++) begin : g_stage
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [pfp_pkg::RW:0] cand;
      logic take;
      if (k == 0) begin : g_first
        assign cand = (pfp_pkg::RW+1)'(sd[0].mag[j]);
      end else begin : g_next
        assign cand = {rr[k][j], 1'b0};
      end
      assign take = cand >= (pfp_pkg::RW+1)'(norm[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          rr[k+1][j] <= take ? pfp_pkg::RW'(cand - (pfp_pkg::RW+1)'(norm[k]))
                             : pfp_pkg::RW'(cand);
          qq[k+1][j] <= {qq[k][j][pfp_pkg::QW-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok[k+1]   <= ok[k];
        norm[k+1] <= norm[k];
        sd[k+1]   <= sd[k];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qr[j] = qq[pfp_pkg::QW][j]
            + pfp_pkg::QW'({rr[pfp_pkg::QW][j], 1'b0} >= (pfp_pkg::RW+1)'(norm[pfp_pkg::QW]));
    end
  end

  function automatic pfp_pkg::unit_t signed_unit(logic [pfp_pkg::QW-1:0] q, logic neg,
                                                 logic keep);
    pfp_pkg::unit_t u;
    u = pfp_pkg::unit_t'({1'b0, q});
    if (neg) u = -u;
    return keep ? u : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vld[pfp_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_plane.ok <= ok[pfp_pkg::QW];
      out_plane.a  <= signed_unit(qr[0], sd[pfp_pkg::QW].neg[0], ok[pfp_pkg::QW]);
      out_plane.b  <= signed_unit(qr[1], sd[pfp_pkg::QW].neg[1], ok[pfp_pkg::QW]);
      out_plane.c  <= signed_unit(qr[2], sd[pfp_pkg::QW].neg[2], ok[pfp_pkg::QW]);
      out_plane.p0 <= sd[pfp_pkg::QW].p0;
    end
  end

  assign out_valid = vout;

endmodule

>>> hdl/plane_from_three_points_unit.sv
// Plane through three points: top level with offset stages, output register and config port.
// One point triple per cycle, back to back, while the output is not stalled; the pipeline has 6
// cross-product and square stages, 50 square-root stages, 32 divide and round stages and 3 offset
// stages ending in the output register, as the root and quotient chains take one bit per stage.
// A stalled output word holds the whole pipeline. min_norm sits at byte address 0.
module plane_from_three_points_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [pfp_pkg::IDW-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // normal_a, normal_b, normal_c, offset_d, zero pad
  output logic [pfp_pkg::ODW-1:0]   m_tdata,
  // plane_valid
  output logic                      m_tuser,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pfp_pkg::AXW-1:0]   paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam logic signed [pfp_pkg::AW-1:0] RND  = pfp_pkg::AW'(64'd1 << (pfp_pkg::UFB - 1));
  localparam logic signed [pfp_pkg::AW-1:0] DMAX = pfp_pkg::AW'((64'd1 << pfp_pkg::CW) - 1);
  localparam logic signed [pfp_pkg::AW-1:0] DMIN = -pfp_pkg::AW'(64'd1 << pfp_pkg::CW);

  logic                    en;
  logic [pfp_pkg::MNW-1:0] min_norm;
  pfp_pkg::tri_t           s_tri;
  logic                    c_valid, r_valid, d_valid;
  logic [pfp_pkg::SW-1:0]  c_sum;
  pfp_pkg::side_t          c_side, r_side;
  logic [pfp_pkg::RW-1:0]  r_root;
  pfp_pkg::plane_t         d_plane, o1, o2;
  logic                    v1, v2;
  logic signed [pfp_pkg::PRW-1:0] pa, pb, pc;
  logic signed [pfp_pkg::AW-1:0]  acc, sh, dsat;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= pfp_pkg::MIN_NORM_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == pfp_pkg::REG_MIN_NORM
                 && paddr[1:0] == 2'b00) begin
      min_norm <= pwdata[pfp_pkg::MNW-1:0];
    end
  end

  assign prdata = (paddr[2] == pfp_pkg::REG_MIN_NORM) ? 32'(min_norm) : '0;

  assign s_tri.p0.x = s_tdata[0*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p0.y = s_tdata[1*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p0.z = s_tdata[2*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p1.x = s_tdata[3*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p1.y = s_tdata[4*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p1.z = s_tdata[5*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p2.x = s_tdata[6*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p2.y = s_tdata[7*pfp_pkg::CW +: pfp_pkg::CW];
  assign s_tri.p2.z = s_tdata[8*pfp_pkg::CW +: pfp_pkg::CW];

  pfp_cross u_cross (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_tri(s_tri),
    .out_valid(c_valid), .out_sum(c_sum), .out_side(c_side)
  );

  pfp_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .in_rad(c_sum), .in_side(c_side),
    .out_valid(r_valid), .out_root(r_root), .out_side(r_side)
  );

  pfp_div u_div (
    .clk(clk), .rst(rst), .en(en), .min_norm(min_norm),
    .in_valid(r_valid), .in_norm(r_root), .in_side(r_side),
    .out_valid(d_valid), .out_plane(d_plane)
  );

  always_comb begin
    sh = acc >>> pfp_pkg::UFB;
    if (sh > DMAX) dsat = DMAX;
    else if (sh < DMIN) dsat = DMIN;
    else dsat = sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= d_valid;
      v2 <= v1;
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1 <= d_plane;
      pa <= d_plane.a * d_plane.p0.x;
      pb <= d_plane.b * d_plane.p0.y;
      pc <= d_plane.c * d_plane.p0.z;
      o2 <= o1;
      acc <= RND - (pfp_pkg::AW'(pa) + pfp_pkg::AW'(pb) + pfp_pkg::AW'(pc));
      m_tdata <= {(pfp_pkg::ODW - 3*pfp_pkg::OW - pfp_pkg::DOW)'(0),
                  o2.ok ? dsat[pfp_pkg::DOW-1:0] : pfp_pkg::DOW'(0),
                  o2.c, o2.b, o2.a};
      m_tuser <= o2.ok;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("degenerate plane with nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      ($signed(m_tdata[31:0]) <= 32'sd1073741824 && $signed(m_tdata[31:0]) >= -32'sd1073741824))
    else $error("normal_a out of unit range");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

>>> bench/tb_plane_from_three_points_unit.sv
// Testbench for the plane-from-three-points unit: random and corner-case point triples.
module tb_plane_from_three_points_unit;
  import pfp_pkg::*;

  typedef logic [8:0][CW-1:0] triple_t;

  typedef struct {
    unit_t                a;
    unit_t                b;
    unit_t                c;
    logic signed [DOW-1:0] d;
    logic                 ok;
  } plane_res_t;

  class plane_board;
    logic [MNW-1:0] min_norm;
    plane_res_t     pending[$];
    int             mismatches;

    function new();
      min_norm = MIN_NORM_RESET;
      mismatches = 0;
    endfunction

    function automatic plane_res_t fit_plane(triple_t t);
      longint     p[9];
      longint     n[3];
      longint     un[3];
      logic [127:0] mg[3];
      logic [127:0] sum, root, trial, q, r;
      longint     acc, dv;
      plane_res_t res;
      for (int i = 0; i < 9; i++) p[i] = longint'(coord_t'(t[i]));
      n[0] = (p[4] - p[1]) * (p[8] - p[2]) - (p[5] - p[2]) * (p[7] - p[1]);
      n[1] = (p[5] - p[2]) * (p[6] - p[0]) - (p[3] - p[0]) * (p[8] - p[2]);
      n[2] = (p[3] - p[0]) * (p[7] - p[1]) - (p[4] - p[1]) * (p[6] - p[0]);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
        sum += mg[i] * mg[i];
      end
      root = 0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= sum) root = trial;
      end
      res = '{0, 0, 0, 0, 1'b0};
      if (root == 0 || root < min_norm) return res;
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] << UFB) / root;
        r = (mg[i] << UFB) % root;
        if (2 * r >= root) q++;
        un[i] = (n[i] < 0) ? -longint'(q) : longint'(q);
      end
      acc = un[0] * p[0] + un[1] * p[1] + un[2] * p[2];
      dv = (-acc + (64'sd1 <<< (UFB - 1))) >>> UFB;
      if (dv > (64'sd1 <<< CW) - 1) dv = (64'sd1 <<< CW) - 1;
      if (dv < -(64'sd1 <<< CW)) dv = -(64'sd1 <<< CW);
      res.a = unit_t'(un[0]);
      res.b = unit_t'(un[1]);
      res.c = unit_t'(un[2]);
      res.d = DOW'(dv);
      res.ok = 1'b1;
      return res;
    endfunction

    function void note_triple(triple_t t);
      pending.insert(pending.size(), fit_plane(t));
    endfunction

    function void check_plane(logic [ODW-1:0] data, logic ok);
      plane_res_t e;
      plane_res_t g;
      g.a = data[31:0];
      g.b = data[63:32];
      g.c = data[95:64];
      g.d = data[96 +: DOW];
      g.ok = ok;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: a=%0d b=%0d c=%0d d=%0d ok=%0b",
                                       g.a, g.b, g.c, g.d, g.ok);
        return;
      end
      e = pending.pop_front();
      if (e.a !== g.a || e.b !== g.b || e.c !== g.c || e.d !== g.d || e.ok !== g.ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp a=%0d b=%0d c=%0d d=%0d ok=%0b",
                    " got a=%0d b=%0d c=%0d d=%0d ok=%0b"},
                   e.a, e.b, e.c, e.d, e.ok, g.a, g.b, g.c, g.d, g.ok);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [IDW-1:0] s_tdata;
  logic [ODW-1:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [AXW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  plane_from_three_points_unit i_dut (.*);

  plane_board board = new();
  bit quiet = 0;
  int idle_cycles = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_triple(triple_t'(s_tdata));
      if (m_tvalid && m_tready) board.check_plane(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic write_min_norm(logic [MNW-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AXW'(REG_MIN_NORM) << 2; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.min_norm = v;
  endtask

  task automatic send_triple(triple_t t);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    coord_t edges[5] = '{coord_t'(24'h7FFFFF), coord_t'(24'h800000), 0, 1, -1};
    int step;
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < 9; i++) t[i] = rand_coord();
      1: begin
        for (int i = 0; i < 3; i++) t[i] = rand_coord();
        step = 1 << $urandom_range(0, 8);
        for (int i = 3; i < 9; i++)
          t[i] = t[i % 3] + coord_t'($signed($urandom_range(0, 2 * step)) - step);
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          t[i] = coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
          step = $signed($urandom_range(0, 4096)) - 2048;
          t[i + 3] = t[i] + coord_t'(step);
          t[i + 6] = t[i] + coord_t'(2 * step);
        end
      end
      default: for (int i = 0; i < 9; i++) t[i] = edges[$urandom_range(0, 4)];
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    triple_t t;
    logic [MNW-1:0] settings[5];
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // corner cases: extremes, coincident and collinear points, axis planes, threshold
    t = '{default: 24'h7FFFFF};                                   send_triple(t);
    t = '{default: 24'h800000};                                   send_triple(t);
    t = '0;                                                       send_triple(t);
    t = '{0: 0, 1: 0, 2: 0, 3: 24'd4096, 4: 0, 5: 0, 6: 0, 7: 24'd4096, 8: 0};
    send_triple(t);
    t = '{0: 0, 1: 0, 2: 24'd4096, 3: 0, 4: 24'd4096, 5: 24'd4096,
          6: 24'd4096, 7: 0, 8: 24'd4096};                        send_triple(t);
    t = '{0: 24'h7FFFFF, 1: 24'h7FFFFF, 2: 24'h7FFFFF, 3: 24'h800000, 4: 24'h7FFFFF,
          5: 24'h7FFFFF, 6: 24'h7FFFFF, 7: 24'h800000, 8: 24'h7FFFFF}; send_triple(t);
    t = '{0: 24'h800000, 1: 24'h800000, 2: 24'h800000, 3: 24'h7FFFFF, 4: 24'h800000,
          5: 24'h800000, 6: 24'h800000, 7: 24'h7FFFFF, 8: 24'h800000}; send_triple(t);
    t = '{0: 1, 1: 2, 2: 3, 3: 2, 4: 4, 5: 6, 6: 3, 7: 6, 8: 9};  send_triple(t);
    t = '{0: 0, 1: 0, 2: 0, 3: 1, 4: 0, 5: 0, 6: 0, 7: 17, 8: 0}; send_triple(t);
    t = '{0: 0, 1: 0, 2: 0, 3: 1, 4: 0, 5: 0, 6: 0, 7: 16, 8: 0}; send_triple(t);
    t = '{0: 0, 1: 0, 2: 0, 3: 1, 4: 0, 5: 0, 6: 0, 7: 0, 8: 1};  send_triple(t);
    t = '{0: 0, 1: 0, 2: 24'h7FFFFF, 3: 24'h7FFFFF, 4: 0, 5: 24'h7FFFFF,
          6: 0, 7: 24'h7FFFFF, 8: 24'h7FFFFF};                    send_triple(t);
    t = '{0: 0, 1: 0, 2: 24'h800000, 3: 24'h7FFFFF, 4: 0, 5: 24'h800000,
          6: 0, 7: 24'h7FFFFF, 8: 24'h800000};                    send_triple(t);
    t = '{0: 24'h555555, 1: 24'hAAAAAA, 2: 24'h123456, 3: 24'hAAAAAA, 4: 24'h555555,
          5: 24'hFEDCBA, 6: 24'h0F0F0F, 7: 24'hF0F0F0, 8: 24'h000FFF}; send_triple(t);
    s_tvalid <= 1'b0;
    wait_drained();

    settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), MIN_NORM_RESET};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_min_norm(settings[ph - 1]);
      quiet = (ph == 5);
      repeat (255) send_triple(rand_triple());
      s_tvalid <= 1'b0;
      wait_drained();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pfp_pkg.sv
hdl/pfp_cross.sv
hdl/pfp_sqrt.sv
hdl/pfp_div.sv
hdl/plane_from_three_points_unit.sv
bench/tb_plane_from_three_points_unit.sv
